### hw/rtl/pcrc8_pkg.sv
// ----------------------------------------------------------------------------
// pcrc8_pkg
// Shared types, constants and the CRC-8 byte update for the packet checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrc8_pkg;

  localparam int unsigned MaxPacketLen = 255;
  localparam int unsigned CountW       = 8;

  localparam logic [7:0] CrcStart = 8'hFF;
  localparam logic [7:0] CrcPoly  = 8'h07;
  localparam logic [7:0] HdrUser  = 8'h01;
  localparam logic [7:0] HdrOs    = 8'h02;

  // count_q saturates here, so the reported length tops out at MaxPacketLen - 1
  localparam logic [CountW-1:0] CountMax = CountW'(MaxPacketLen - 1);

  typedef enum logic [2:0] {
    VerdictShort   = 3'd0,
    VerdictCrcFail = 3'd1,
    VerdictUser    = 3'd2,
    VerdictOs      = 3'd3,
    VerdictUnknown = 3'd4
  } verdict_e;

  typedef struct packed {
    verdict_e           verdict;
    logic [CountW-1:0]  payload_len;
  } result_t;

  // CRC-8, poly 0x07, MSB first, one byte per call
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (x[7]) begin
        x = {x[6:0], 1'b0} ^ CrcPoly;
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/packet_crc8_check_and_route.sv
// ----------------------------------------------------------------------------
// packet_crc8_check_and_route
// Packet byte stream in, one CRC-8 check / routing verdict out per packet.
// ----------------------------------------------------------------------------
// Bytes enter on the slave stream, one per word, tlast on the CRC byte. Each
// byte is registered and then, unless it is the last, folded into the
// running CRC-8 (poly 0x07, init 0xFF); on tlast the verdict word is loaded
// into the output register from the input register. One byte is taken every
// cycle; the input register drains into the output register in parallel
// with the sink taking the previous verdict, so only a stalled sink holding
// a verdict while another last byte is pending stops the input.
`default_nettype none

module packet_crc8_check_and_route (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic        s_axis_tlast_i,   // is_last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [2:0] verdict, [10:3] payload_len, rest 0
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q, out_vld_d;
  pcrc8_pkg::result_t res_q;
  pcrc8_pkg::result_t res;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  pcrc8_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (res)
  );

  always_comb begin
    in_vld_d = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    if (advance && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_last_q) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, res_q.payload_len, res_q.verdict};

  // only user-data verdicts carry a length, and that length is never zero
  a_len_only_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.verdict != pcrc8_pkg::VerdictUser) |-> res_q.payload_len == '0)
    else $error("payload_len set on non-user verdict");

  a_user_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.verdict == pcrc8_pkg::VerdictUser) |-> res_q.payload_len != '0)
    else $error("user verdict with zero length");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready_o)
    else $error("input stalled with empty input register");

  // a stalled last byte implies a verdict is waiting on the sink
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |-> in_last_q && out_vld_q && !m_axis_tready_i)
    else $error("input register held without cause");

endmodule

`default_nettype wire

### hw/rtl/pcrc8_core.sv
// ----------------------------------------------------------------------------
// pcrc8_core
// Per-packet state (running CRC, byte count, header) and the verdict logic.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc8_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,   // one byte consumed this cycle
  input  wire logic [7:0]          byte_i,
  input  wire logic                last_i,
  output pcrc8_pkg::result_t       result_o  // meaningful when last_i is set
);

  logic [7:0]                   crc_q, crc_d;
  logic [pcrc8_pkg::CountW-1:0] count_q, count_d;
  logic [7:0]                   header_q, header_d;

  always_comb begin
    crc_d    = crc_q;
    count_d  = count_q;
    header_d = header_q;
    if (step_i) begin
      if (last_i) begin
        crc_d   = pcrc8_pkg::CrcStart;
        count_d = '0;
      end else begin
        if (count_q == '0) begin
          header_d = byte_i;
        end
        crc_d = pcrc8_pkg::crc8_byte(crc_q, byte_i);
        if (count_q < pcrc8_pkg::CountMax) begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= pcrc8_pkg::CrcStart;
      count_q  <= '0;
      header_q <= '0;
    end else begin
      crc_q    <= crc_d;
      count_q  <= count_d;
      header_q <= header_d;
    end
  end

  always_comb begin
    result_o.payload_len = '0;
    priority if (count_q == '0) begin
      // lone last byte: too short, not checked
      result_o.verdict = pcrc8_pkg::VerdictShort;
    end else if (byte_i != crc_q) begin
      result_o.verdict = pcrc8_pkg::VerdictCrcFail;
    end else if (header_q == pcrc8_pkg::HdrUser) begin
      result_o.verdict     = pcrc8_pkg::VerdictUser;
      result_o.payload_len = count_q;
    end else if (header_q == pcrc8_pkg::HdrOs) begin
      result_o.verdict = pcrc8_pkg::VerdictOs;
    end else begin
      result_o.verdict = pcrc8_pkg::VerdictUnknown;
    end
  end

endmodule

`default_nettype wire
